[rtl/ftrc_pkg.sv]
// Shared types, widths and constant tables for the three-rule fuzzy controller.
// Depends on nothing; imported by ftrc_div_stage, fuzzy_three_rule_controller and its testbench.
`timescale 1ns / 1ps

package ftrc_pkg;

	// fixed-point grades: unsigned, FRAC_BITS fractional bits, 1.0 is reachable
	localparam int FRAC_BITS  = 16;
	localparam int AGG_W      = FRAC_BITS + 1;
	// eleven grades of at most 1.0 each
	localparam int AREA_W     = FRAC_BITS + 5;
	// one-sided moment is at most 15 * 1.0
	localparam int MAG_W      = FRAC_BITS + 4;
	// divisor enters the divider pre-shifted by two places
	localparam int DVS_W      = AREA_W + 2;
	localparam int QUO_W      = 3;
	localparam int LEVEL_W    = 4;
	localparam int SET_POINTS = 11;
	localparam int CENTER     = 5;

	localparam logic signed [LEVEL_W-1:0] NO_FIRE_LEVEL = 4'sd5;

	// rule indexes
	localparam logic [1:0] RULE_HOT  = 2'd0;
	localparam logic [1:0] RULE_MID  = 2'd1;
	localparam logic [1:0] RULE_COLD = 2'd2;

	// one item in flight through the divider
	typedef struct packed {
		logic               neg;
		logic               fired;
		logic [MAG_W-1:0]   rem;
		logic [DVS_W-1:0]   dvs;
		logic [QUO_W-1:0]   quo;
	} div_t;

	// n/12 in fixed point, n = 0..12
	function automatic logic [AGG_W-1:0] frac12(input logic [3:0] n);
		logic [AGG_W-1:0] r;
		case (n)
			4'd1:    r = AGG_W'((64'd1 << FRAC_BITS) / 12);
			4'd2:    r = AGG_W'((64'd2 << FRAC_BITS) / 12);
			4'd3:    r = AGG_W'((64'd3 << FRAC_BITS) / 12);
			4'd4:    r = AGG_W'((64'd4 << FRAC_BITS) / 12);
			4'd5:    r = AGG_W'((64'd5 << FRAC_BITS) / 12);
			4'd6:    r = AGG_W'((64'd6 << FRAC_BITS) / 12);
			4'd7:    r = AGG_W'((64'd7 << FRAC_BITS) / 12);
			4'd8:    r = AGG_W'((64'd8 << FRAC_BITS) / 12);
			4'd9:    r = AGG_W'((64'd9 << FRAC_BITS) / 12);
			4'd10:   r = AGG_W'((64'd10 << FRAC_BITS) / 12);
			4'd11:   r = AGG_W'((64'd11 << FRAC_BITS) / 12);
			4'd12:   r = AGG_W'((64'd12 << FRAC_BITS) / 12);
			default: r = '0;
		endcase
		return r;
	endfunction

	// n/10 in fixed point, n = 0..10
	function automatic logic [AGG_W-1:0] frac10(input logic [3:0] n);
		logic [AGG_W-1:0] r;
		case (n)
			4'd1:    r = AGG_W'((64'd1 << FRAC_BITS) / 10);
			4'd2:    r = AGG_W'((64'd2 << FRAC_BITS) / 10);
			4'd3:    r = AGG_W'((64'd3 << FRAC_BITS) / 10);
			4'd4:    r = AGG_W'((64'd4 << FRAC_BITS) / 10);
			4'd5:    r = AGG_W'((64'd5 << FRAC_BITS) / 10);
			4'd6:    r = AGG_W'((64'd6 << FRAC_BITS) / 10);
			4'd7:    r = AGG_W'((64'd7 << FRAC_BITS) / 10);
			4'd8:    r = AGG_W'((64'd8 << FRAC_BITS) / 10);
			4'd9:    r = AGG_W'((64'd9 << FRAC_BITS) / 10);
			4'd10:   r = AGG_W'((64'd10 << FRAC_BITS) / 10);
			default: r = '0;
		endcase
		return r;
	endfunction

	// output-set grade in fifths for one rule at point i (x = i - 5)
	function automatic logic [2:0] set_fifths(input logic [1:0] rule, input logic [3:0] i);
		logic [2:0] k;
		k = 3'd0;
		case (rule)
			RULE_HOT:  if (i < 4'd5) k = 3'(4'd5 - i);
			RULE_MID:  if (i == 4'd5) k = 3'd5;
			RULE_COLD: if (i > 4'd5 && i < 4'd11) k = 3'(i - 4'd5);
			default:   k = 3'd0;
		endcase
		return k;
	endfunction

	// k/5 in fixed point
	function automatic logic [AGG_W-1:0] grade5(input logic [2:0] k);
		logic [AGG_W-1:0] r;
		case (k)
			3'd1:    r = AGG_W'((64'd1 << FRAC_BITS) / 5);
			3'd2:    r = AGG_W'((64'd2 << FRAC_BITS) / 5);
			3'd3:    r = AGG_W'((64'd3 << FRAC_BITS) / 5);
			3'd4:    r = AGG_W'((64'd4 << FRAC_BITS) / 5);
			3'd5:    r = AGG_W'((64'd5 << FRAC_BITS) / 5);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

[rtl/fuzzy_three_rule_controller.sv]
// Top level of the three-rule max-min fuzzy controller with centroid output.
// Depends on ftrc_pkg and ftrc_div_stage.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+------------------------------
//   input   | in_valid  | in_stall  | temperature[7:0]
//   output  | out_valid | out_stall | drive_level[3:0] s, fired
//
// One item per cycle sustained while out_stall stays low; each item passes seven
// register stages: membership lookup, max-min aggregate, sums, sign/magnitude,
// and three restoring-division stages of one quotient bit each.
// Reset clears all stage valid bits; the data registers are not reset.
// out_stall freezes a full last stage and every full stage whose successor is
// frozen; in_stall rises only when the first stage is full and cannot move.
`timescale 1ns / 1ps

module fuzzy_three_rule_controller import ftrc_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [7:0]                temperature,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [LEVEL_W-1:0] drive_level,
	output logic                      fired
);

	// stage valids and advance enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic en1, en2, en3, en4, en5, en6, en7;

	assign en7 = !v_s7 || !out_stall;
	assign en6 = !v_s6 || en7;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// stage 1: rule memberships
	logic [AGG_W-1:0] u_hot, u_mid, u_cold;
	logic [AGG_W-1:0] u_s1 [3];

	always_comb begin
		u_hot  = '0;
		u_mid  = '0;
		u_cold = '0;
		if (temperature >= 8'd74 && temperature <= 8'd86)
			u_hot = frac12(4'(temperature - 8'd74));
		if (temperature >= 8'd60 && temperature <= 8'd70)
			u_mid = frac10(4'(temperature - 8'd60));
		else if (temperature > 8'd70 && temperature <= 8'd80)
			u_mid = frac10(4'(8'd80 - temperature));
		if (temperature >= 8'd54 && temperature <= 8'd66)
			u_cold = frac12(4'(8'd66 - temperature));
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			u_s1[RULE_HOT]  <= u_hot;
			u_s1[RULE_MID]  <= u_mid;
			u_s1[RULE_COLD] <= u_cold;
		end
	end

	// stage 2: clip each output set and take the max per point
	logic [AGG_W-1:0] agg     [SET_POINTS];
	logic [AGG_W-1:0] agg_s2  [SET_POINTS];

	always_comb begin
		for (int i = 0; i < SET_POINTS; i++) begin
			agg[i] = '0;
			for (int r = 0; r < 3; r++) begin
				logic [AGG_W-1:0] g;
				logic [AGG_W-1:0] c;
				g = grade5(set_fifths(2'(r), 4'(i)));
				c = (u_s1[r] < g) ? u_s1[r] : g;
				if (c > agg[i]) agg[i] = c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			for (int i = 0; i < SET_POINTS; i++) agg_s2[i] <= agg[i];
		end
	end

	// stage 3: area and the two one-sided moments
	logic [AREA_W-1:0] area;
	logic [MAG_W-1:0]  pos_sum, neg_sum;
	logic [AREA_W-1:0] area_s3;
	logic [MAG_W-1:0]  pos_s3, neg_s3;

	always_comb begin
		area    = '0;
		pos_sum = '0;
		neg_sum = '0;
		for (int i = 0; i < SET_POINTS; i++) begin
			area = area + AREA_W'(agg_s2[i]);
			if (i > CENTER)
				pos_sum = pos_sum + MAG_W'(agg_s2[i]) * MAG_W'(i - CENTER);
			else if (i < CENTER)
				neg_sum = neg_sum + MAG_W'(agg_s2[i]) * MAG_W'(CENTER - i);
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			area_s3 <= area;
			pos_s3  <= pos_sum;
			neg_s3  <= neg_sum;
		end
	end

	// stage 4: sign and magnitude of the moment, divisor pre-shifted
	div_t prep, d_s4, d_s5, d_s6, d_s7;

	always_comb begin
		prep.neg   = neg_s3 > pos_s3;
		prep.fired = area_s3 != '0;
		prep.rem   = prep.neg ? (neg_s3 - pos_s3) : (pos_s3 - neg_s3);
		prep.dvs   = DVS_W'(area_s3) << (QUO_W - 1);
		prep.quo   = '0;
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			d_s4 <= prep;
		end
	end

	// stages 5..7: one quotient bit each, most significant first
	ftrc_div_stage u_div5 (
		.clk(clk), .arst_n(arst_n), .en(en5),
		.vld_in(v_s4), .d(d_s4), .vld_out(v_s5), .q(d_s5)
	);

	ftrc_div_stage u_div6 (
		.clk(clk), .arst_n(arst_n), .en(en6),
		.vld_in(v_s5), .d(d_s5), .vld_out(v_s6), .q(d_s6)
	);

	ftrc_div_stage u_div7 (
		.clk(clk), .arst_n(arst_n), .en(en7),
		.vld_in(v_s6), .d(d_s6), .vld_out(v_s7), .q(d_s7)
	);

	// result: signed quotient, or the no-fire level
	logic signed [LEVEL_W-1:0] lvl_mag;

	assign lvl_mag     = LEVEL_W'({1'b0, d_s7.quo});
	assign out_valid   = v_s7;
	assign fired       = d_s7.fired;
	assign drive_level = !d_s7.fired ? NO_FIRE_LEVEL
	                   : (d_s7.neg ? LEVEL_W'(4'sd0 - lvl_mag) : lvl_mag);

	// input is held back only when the first stage is full
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s1)
		else $error("in_stall high with stage 1 empty");

	// centroid quotient never exceeds five when a rule fired
	a_quo_range: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s7 && d_s7.fired) |-> (d_s7.quo <= 3'd5))
		else $error("centroid quotient out of range");

	// an item moving out of stage 4 arrives in stage 5 with its fired flag unchanged
	a_fired_area: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && en5) |=> (v_s5 && (d_s5.fired == $past(d_s4.fired))))
		else $error("fired flag lost between stage 4 and stage 5");

	// a frozen last stage keeps its item
	a_hold_last: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s7 && out_stall) |=> (v_s7 && $stable(d_s7)))
		else $error("last stage changed while stalled");

endmodule

[rtl/ftrc_div_stage.sv]
// One restoring-division step of the centroid divider, with its stage register.
// Depends on ftrc_pkg (div_t and widths).
`timescale 1ns / 1ps

module ftrc_div_stage import ftrc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic vld_in,
	input  div_t d,
	output logic vld_out,
	output div_t q
);

	logic ge;
	div_t nxt;

	// compare and subtract one quotient bit, then halve the divisor
	always_comb begin
		ge = (DVS_W'(d.rem) >= d.dvs);
		nxt       = d;
		nxt.rem   = ge ? MAG_W'(DVS_W'(d.rem) - d.dvs) : d.rem;
		nxt.dvs   = d.dvs >> 1;
		nxt.quo   = {d.quo[QUO_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

[dv/fuzzy_three_rule_controller_tb.sv]
// Self-checking testbench for the three-rule max-min fuzzy controller.
// Depends on ftrc_pkg and the RTL of fuzzy_three_rule_controller; it reads no files.
`timescale 1ns / 1ps

module fuzzy_three_rule_controller_tb import ftrc_pkg::*;;

	localparam int RANDOM_ITEMS = 600;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int TAIL_CYCLES  = 20;

	// one drive result as it leaves the block
	typedef struct {
		logic signed [LEVEL_W-1:0] level;
		logic                      fired;
	} drive_t;

	// directed stimulus row; known marks a result typed in by hand
	typedef struct {
		logic [7:0]                temp;
		bit                        known;
		logic signed [LEVEL_W-1:0] level;
		logic                      fired;
	} stim_row_t;

	localparam int DIRECTED_ITEMS = 24;
	localparam int TOTAL_ITEMS    = DIRECTED_ITEMS + RANDOM_ITEMS;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic [7:0]                temperature;
	logic                      out_valid;
	logic                      out_stall;
	logic signed [LEVEL_W-1:0] drive_level;
	logic                      fired;

	drive_t    drive_queue[$];
	stim_row_t stim_table[DIRECTED_ITEMS];
	int        fault_count;
	int        cycle_count = 0;
	int        send_gap_pct;
	int        stall_pct;

	fuzzy_three_rule_controller uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.temperature (temperature),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.drive_level (drive_level),
		.fired       (fired)
	);

	// 8 ns clock
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// grade of one rule's membership, fixed point
	function automatic longint unsigned temp_grade(input logic [1:0] rule, input int t);
		longint unsigned g;
		g = 0;
		case (rule)
			RULE_HOT: begin
				if (t >= 74 && t <= 86) g = (longint'(t - 74) << FRAC_BITS) / 12;
			end
			RULE_MID: begin
				if (t >= 60 && t <= 70) g = (longint'(t - 60) << FRAC_BITS) / 10;
				else if (t > 70 && t <= 80) g = (longint'(80 - t) << FRAC_BITS) / 10;
			end
			RULE_COLD: begin
				if (t >= 54 && t <= 66) g = (longint'(66 - t) << FRAC_BITS) / 12;
			end
			default: g = 0;
		endcase
		return g;
	endfunction

	// output set height in fifths at point i (x = i - 5)
	function automatic int set_height(input logic [1:0] rule, input int i);
		int k;
		k = 0;
		case (rule)
			RULE_HOT:  k = (i < CENTER) ? CENTER - i : 0;
			RULE_MID:  k = (i == CENTER) ? 5 : 0;
			RULE_COLD: k = (i > CENTER) ? i - CENTER : 0;
			default:   k = 0;
		endcase
		return k;
	endfunction

	// clip, aggregate by max, then centroid truncated toward zero
	function automatic drive_t centroid_of(input logic [7:0] temp);
		logic [1:0]      rules[3];
		longint unsigned agg[SET_POINTS];
		longint unsigned mu;
		longint unsigned h;
		longint unsigned c;
		longint          area;
		longint          moment;
		drive_t          d;
		rules = '{RULE_HOT, RULE_MID, RULE_COLD};
		foreach (agg[i]) agg[i] = 0;
		d.fired = 1'b0;
		foreach (rules[r]) begin
			mu = temp_grade(rules[r], int'(temp));
			if (mu != 0) begin
				d.fired = 1'b1;
				for (int i = 0; i < SET_POINTS; i++) begin
					h = (longint'(set_height(rules[r], i)) << FRAC_BITS) / 5;
					c = (mu < h) ? mu : h;
					if (c > agg[i]) agg[i] = c;
				end
			end
		end
		area = 0;
		moment = 0;
		for (int i = 0; i < SET_POINTS; i++) begin
			area += longint'(agg[i]);
			moment += longint'(i - CENTER) * longint'(agg[i]);
		end
		if (area == 0) begin
			d.level = NO_FIRE_LEVEL;
			d.fired = 1'b0;
		end else begin
			d.level = LEVEL_W'(moment / area);
		end
		return d;
	endfunction

	task automatic log_fault(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		fault_count++;
	endtask

	// present one item, wait for it to be taken, queue its expected result
	task automatic send_item(input logic [7:0] t, input drive_t want);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			temperature <= 8'($urandom);
			@(posedge clk);
		end
		in_valid <= 1'b1;
		temperature <= t;
		do @(posedge clk); while (in_stall);
		drive_queue.push_back(want);
	endtask

	// pick idle rates for the item's share of the run
	task automatic set_phase(input int idx);
		if (idx < TOTAL_ITEMS / 3) begin
			send_gap_pct = 19;
			stall_pct = 73;
		end else if (idx < 2 * TOTAL_ITEMS / 3) begin
			send_gap_pct = 73;
			stall_pct = 19;
		end else begin
			send_gap_pct = 0;
			stall_pct = 0;
		end
	endtask

	// directed rows: range edges, rule overlaps, nothing firing
	initial begin
		stim_table = '{
			'{8'd0,   1'b1, NO_FIRE_LEVEL, 1'b0},
			'{8'd255, 1'b1, NO_FIRE_LEVEL, 1'b0},
			'{8'd53,  1'b1, NO_FIRE_LEVEL, 1'b0},
			'{8'd87,  1'b1, NO_FIRE_LEVEL, 1'b0},
			'{8'd128, 1'b1, NO_FIRE_LEVEL, 1'b0},
			'{8'd70,  1'b1, 4'sd0, 1'b1},
			'{8'd54,  1'b0, 4'sd0, 1'b0},
			'{8'd55,  1'b0, 4'sd0, 1'b0},
			'{8'd59,  1'b0, 4'sd0, 1'b0},
			'{8'd60,  1'b0, 4'sd0, 1'b0},
			'{8'd61,  1'b0, 4'sd0, 1'b0},
			'{8'd65,  1'b0, 4'sd0, 1'b0},
			'{8'd66,  1'b0, 4'sd0, 1'b0},
			'{8'd67,  1'b0, 4'sd0, 1'b0},
			'{8'd69,  1'b0, 4'sd0, 1'b0},
			'{8'd71,  1'b0, 4'sd0, 1'b0},
			'{8'd73,  1'b0, 4'sd0, 1'b0},
			'{8'd74,  1'b0, 4'sd0, 1'b0},
			'{8'd75,  1'b0, 4'sd0, 1'b0},
			'{8'd79,  1'b0, 4'sd0, 1'b0},
			'{8'd80,  1'b0, 4'sd0, 1'b0},
			'{8'd81,  1'b0, 4'sd0, 1'b0},
			'{8'd85,  1'b0, 4'sd0, 1'b0},
			'{8'd86,  1'b0, 4'sd0, 1'b0}
		};
	end

	// reset, stimulus and end of run
	initial begin
		drive_t     want;
		logic [7:0] t;
		fault_count = 0;
		send_gap_pct = 19;
		stall_pct = 73;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		temperature <= 8'd0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int n = 0; n < DIRECTED_ITEMS; n++) begin
			set_phase(n);
			if (stim_table[n].known) begin
				want.level = stim_table[n].level;
				want.fired = stim_table[n].fired;
			end else begin
				want = centroid_of(stim_table[n].temp);
			end
			send_item(stim_table[n].temp, want);
		end

		// mostly the active band around the rules, the rest anywhere
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			set_phase(DIRECTED_ITEMS + n);
			if ($urandom_range(99) < 70) t = 8'($urandom_range(90, 50));
			else t = 8'($urandom_range(255, 0));
			send_item(t, centroid_of(t));
		end
		in_valid <= 1'b0;

		while (drive_queue.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fault_count == 0) begin
			$display("fuzzy_three_rule_controller_tb: done, clean");
		end else begin
			$display("fuzzy_three_rule_controller_tb: done, errors");
		end
		$finish;
	end

	// receiver back-pressure
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// compare each taken result with the oldest expectation
	always @(posedge clk) begin
		drive_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (drive_queue.size() == 0) begin
				log_fault($sformatf("unexpected result level=%0d fired=%0b",
					drive_level, fired));
			end else begin
				want = drive_queue.pop_front();
				if (drive_level !== want.level)
					log_fault($sformatf("drive_level %0d, expected %0d",
						drive_level, want.level));
				if (fired !== want.fired)
					log_fault($sformatf("fired %0b, expected %0b", fired, want.fired));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("fuzzy_three_rule_controller_tb: done, errors");
			$finish;
		end
	end

endmodule
